// ----- sv/bffa_pkg.sv -----
package bffa_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [63:0] HeaderBits = 64'h48;
  localparam logic [63:0] AllOnes = 64'hffff_ffff_ffff_ffff;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SET_END = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_FROM_FRAG = 3'd0,
    ST_FROM_END  = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_END_SET   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_SHIFT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] address;
    logic [63:0] length;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] block_start;
    logic        remainder_valid;
    logic [63:0] remainder_start;
    logic [63:0] remainder_length;
  } out_t;

  // one fragment entry
  typedef struct packed {
    logic [63:0] start;
    logic [63:0] length;
  } frag_t;

  // controls from the sequencer to every cell
  typedef struct packed {
    logic        rotate;   // shift ring by one toward index 0
    logic        append;   // load append into first free slot (index count)
    logic        write;    // replace head with wdata as it wraps during update pass
    logic        skip;     // drop slot zero (compaction)
    frag_t       wdata;
  } cell_ctl_t;

endpackage

// ----- sv/bffa_cell.sv -----
// one table slot: loads from its upper neighbor on rotate
module bffa_cell (
  input  logic              clk_i,
  input  logic              load_i,
  input  bffa_pkg::frag_t   d_i,
  output bffa_pkg::frag_t   q_o
);

  bffa_pkg::frag_t ent_q;

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= d_i;
    end
  end

  assign q_o = ent_q;

endmodule

// ----- sv/bffa_ring.sv -----
// ring of cells; slot 0 is the head, rotate moves slot k+1 into slot k
// and the head into slot count-1, so a full pass visits every entry
module bffa_ring (
  input  logic                      clk_i,
  input  logic [bffa_pkg::CntW-1:0] count_i,
  input  bffa_pkg::cell_ctl_t       ctl_i,
  output bffa_pkg::frag_t           head_o
);

  bffa_pkg::frag_t q [bffa_pkg::TableDepth];
  bffa_pkg::frag_t d [bffa_pkg::TableDepth];
  logic ld [bffa_pkg::TableDepth];

  // neighbor hand-off; wrap slot is count-1 (not written back when dropping head)
  always_comb begin
    for (int k = 0; k < bffa_pkg::TableDepth; k++) begin
      ld[k] = 1'b0;
      d[k]  = q[k];
      if (ctl_i.append) begin
        ld[k] = (count_i == bffa_pkg::CntW'(k));
        d[k]  = ctl_i.wdata;
      end else if (ctl_i.rotate) begin
        ld[k] = 1'b1;
        if (k + 1 < bffa_pkg::TableDepth) begin
          d[k] = q[k+1];
        end
        if (!ctl_i.skip && count_i == bffa_pkg::CntW'(k + 1)) begin
          d[k] = ctl_i.write ? ctl_i.wdata : q[0];
        end
      end
    end
  end

  for (genvar g = 0; g < bffa_pkg::TableDepth; g++) begin : g_cell
    bffa_cell u_cell (
      .clk_i (clk_i),
      .load_i(ld[g]),
      .d_i   (d[g]),
      .q_o   (q[g])
    );
  end

  assign head_o = q[0];

endmodule

// ----- sv/best_fit_fragment_allocator_core.sv -----
// sequence: release and set_end pass through S_APPLY and raise the result beat in S_OUT;
// allocate first scans one pass over the ring in S_SCAN, one entry per cycle; from the end
// pointer it then goes through S_APPLY to S_OUT; from a fragment it adds an update pass
// in S_SHIFT before S_OUT.
// throughput: one item at a time, next accept once the result beat is taken.
// reset: async active low clears entry count, end pointer and control state only.
module best_fit_fragment_allocator_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bffa_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bffa_pkg::out_t   out_data_o
);

  bffa_pkg::state_e state_q, state_d;
  bffa_pkg::in_t req_q;
  bffa_pkg::out_t res_q, res_d;
  logic [bffa_pkg::CntW-1:0] count_q, count_d;
  logic [bffa_pkg::CntW-1:0] step_q, step_d;
  logic [bffa_pkg::IdxW-1:0] pick_q, pick_d;
  logic [63:0] best_q, best_d, end_q, end_d;
  logic found_q, found_d;
  bffa_pkg::cell_ctl_t ctl;
  bffa_pkg::frag_t head;
  logic [63:0] diff;
  logic fits;
  logic in_acc, out_acc;

  bffa_ring u_ring (
    .clk_i  (clk_i),
    .count_i(count_q),
    .ctl_i  (ctl),
    .head_o (head)
  );

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // candidate test on the head entry
  assign diff = head.length - req_q.length;
  assign fits = (head.length >= req_q.length) &&
                !(diff != 64'd0 && diff < bffa_pkg::HeaderBits) &&
                (diff < best_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bffa_pkg::S_IDLE: begin
        if (in_acc && in_data_i.operation == bffa_pkg::OP_ALLOC) begin
          state_d = bffa_pkg::S_SCAN;
        end else if (in_acc && in_data_i.operation != bffa_pkg::OP_NONE) begin
          state_d = bffa_pkg::S_APPLY;
        end
      end
      bffa_pkg::S_SCAN: begin
        if (step_q == count_q) state_d = bffa_pkg::S_APPLY;
      end
      bffa_pkg::S_APPLY: begin
        if (req_q.operation == bffa_pkg::OP_ALLOC && found_q) begin
          state_d = bffa_pkg::S_SHIFT;
        end else begin
          state_d = bffa_pkg::S_OUT;
        end
      end
      bffa_pkg::S_SHIFT: begin
        if (step_q == count_q) state_d = bffa_pkg::S_OUT;
      end
      bffa_pkg::S_OUT: begin
        if (out_acc) state_d = bffa_pkg::S_IDLE;
      end
      default: state_d = bffa_pkg::S_IDLE;
    endcase
  end

  // datapath and ring controls
  always_comb begin
    ctl     = '0;
    count_d = count_q;
    step_d  = step_q;
    pick_d  = pick_q;
    best_d  = best_q;
    found_d = found_q;
    end_d   = end_q;
    res_d   = res_q;
    unique case (state_q)
      bffa_pkg::S_IDLE: begin
        step_d  = '0;
        best_d  = bffa_pkg::AllOnes;
        found_d = 1'b0;
        pick_d  = '0;
        res_d   = '0;
      end
      bffa_pkg::S_SCAN: begin
        // rotate a full pass, head is entry step_q
        if (step_q != count_q) begin
          ctl.rotate = 1'b1;
          step_d = step_q + 1'b1;
          if (fits) begin
            best_d  = diff;
            pick_d  = step_q[bffa_pkg::IdxW-1:0];
            found_d = 1'b1;
          end
        end
      end
      bffa_pkg::S_APPLY: begin
        step_d = '0;
        unique case (req_q.operation)
          bffa_pkg::OP_ALLOC: begin
            if (!found_q) begin
              res_d.status      = bffa_pkg::ST_FROM_END;
              res_d.block_start = end_q;
              end_d = end_q + bffa_pkg::HeaderBits + req_q.length;
            end else begin
              res_d.status = bffa_pkg::ST_FROM_FRAG;
            end
          end
          bffa_pkg::OP_RELEASE: begin
            if (count_q < bffa_pkg::CntW'(bffa_pkg::TableDepth)) begin
              ctl.append       = 1'b1;
              ctl.wdata.start  = req_q.address;
              ctl.wdata.length = req_q.length;
              count_d      = count_q + 1'b1;
              res_d.status = bffa_pkg::ST_RELEASED;
            end else begin
              res_d.status = bffa_pkg::ST_FULL;
            end
          end
          bffa_pkg::OP_SET_END: begin
            end_d        = req_q.address;
            res_d.status = bffa_pkg::ST_END_SET;
          end
          default: ;
        endcase
      end
      bffa_pkg::S_SHIFT: begin
        // second pass: update or drop the picked entry, only once per pass
        if (step_q != count_q) begin
          ctl.rotate = 1'b1;
          step_d = step_q + 1'b1;
          if (found_q && step_q[bffa_pkg::IdxW-1:0] == pick_q) begin
            found_d = 1'b0;
            res_d.block_start = head.start;
            if (best_q != 64'd0) begin
              ctl.write = 1'b1;
              ctl.wdata.start  = head.start + bffa_pkg::HeaderBits + req_q.length;
              ctl.wdata.length = best_q - bffa_pkg::HeaderBits;
              res_d.remainder_valid  = 1'b1;
              res_d.remainder_start  = ctl.wdata.start;
              res_d.remainder_length = ctl.wdata.length;
            end else begin
              ctl.skip = 1'b1;
              count_d  = count_q - 1'b1;
              step_d   = step_q;
            end
          end
        end
      end
      bffa_pkg::S_OUT: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bffa_pkg::S_IDLE;
      count_q <= '0;
      end_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      end_q   <= end_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) req_q <= in_data_i;
    step_q  <= step_d;
    pick_q  <= pick_d;
    best_q  <= best_d;
    found_q <= found_d;
    res_q   <= res_d;
  end

  // handshake outputs
  always_comb begin
    in_stall_o  = (state_q != bffa_pkg::S_IDLE);
    out_valid_o = (state_q == bffa_pkg::S_OUT);
    out_data_o  = res_q;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bffa_pkg::CntW'(bffa_pkg::TableDepth))
    else $error("entry count above table depth");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bffa_pkg::S_IDLE) |-> in_stall_o)
    else $error("input taken while busy");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result beat changed while stalled");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bffa_pkg::S_SCAN) |-> (step_q <= count_q))
    else $error("scan ran past entry count");

endmodule
